[sv/fjot_pkg.sv]
// Package for the flat JSON object tokenizer.
// Phase codes, result kinds, error codes, input opcodes, character codes, the step result type and helpers.
// No dependencies.
package fjot_pkg;

  localparam int PhaseW = 4;
  localparam int KindW  = 3;
  localparam int ErrW   = 3;
  localparam int ByteW  = 8;

  // parse phases
  localparam logic [PhaseW-1:0] PH_START       = 4'd0;
  localparam logic [PhaseW-1:0] PH_AFTER_OPEN  = 4'd1;
  localparam logic [PhaseW-1:0] PH_KEY         = 4'd2;
  localparam logic [PhaseW-1:0] PH_KEY_ESC     = 4'd3;
  localparam logic [PhaseW-1:0] PH_AFTER_KEY   = 4'd4;
  localparam logic [PhaseW-1:0] PH_BEFORE_VAL  = 4'd5;
  localparam logic [PhaseW-1:0] PH_VAL         = 4'd6;
  localparam logic [PhaseW-1:0] PH_VAL_ESC     = 4'd7;
  localparam logic [PhaseW-1:0] PH_AFTER_VAL   = 4'd8;
  localparam logic [PhaseW-1:0] PH_AFTER_COMMA = 4'd9;
  localparam logic [PhaseW-1:0] PH_KEY_WS      = 4'd10;
  localparam logic [PhaseW-1:0] PH_DONE        = 4'd11;
  localparam logic [PhaseW-1:0] PH_FAILED      = 4'd12;

  // result kinds
  localparam logic [KindW-1:0] K_KEY_BYTE = 3'd0;
  localparam logic [KindW-1:0] K_VAL_BYTE = 3'd1;
  localparam logic [KindW-1:0] K_KEY_END  = 3'd2;
  localparam logic [KindW-1:0] K_VAL_END  = 3'd3;
  localparam logic [KindW-1:0] K_OK       = 3'd4;
  localparam logic [KindW-1:0] K_ERR      = 3'd5;

  // error codes
  localparam logic [ErrW-1:0] E_NO_BRACE = 3'd0;
  localparam logic [ErrW-1:0] E_QUOTE    = 3'd1;
  localparam logic [ErrW-1:0] E_COLON    = 3'd2;
  localparam logic [ErrW-1:0] E_COMMA    = 3'd3;
  localparam logic [ErrW-1:0] E_UNTERM   = 3'd4;

  // input opcodes
  localparam logic OP_TEXT = 1'b0;
  localparam logic OP_END  = 1'b1;

  // characters
  localparam logic [ByteW-1:0] CH_LBRACE = 8'h7B;
  localparam logic [ByteW-1:0] CH_RBRACE = 8'h7D;
  localparam logic [ByteW-1:0] CH_COLON  = 8'h3A;
  localparam logic [ByteW-1:0] CH_COMMA  = 8'h2C;
  localparam logic [ByteW-1:0] CH_QUOTE  = 8'h22;
  localparam logic [ByteW-1:0] CH_BSLASH = 8'h5C;
  localparam logic [ByteW-1:0] CH_N      = 8'h6E;
  localparam logic [ByteW-1:0] CH_R      = 8'h72;
  localparam logic [ByteW-1:0] CH_T      = 8'h74;
  localparam logic [ByteW-1:0] CH_LF     = 8'h0A;
  localparam logic [ByteW-1:0] CH_CR     = 8'h0D;
  localparam logic [ByteW-1:0] CH_TAB    = 8'h09;
  localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic             vld;
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data;
    logic [ErrW-1:0]  err;
  } step_res_t;

  function automatic logic is_ws(input logic [ByteW-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [ByteW-1:0] unescape(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    case (c)
      CH_N:    r = CH_LF;
      CH_R:    r = CH_CR;
      CH_T:    r = CH_TAB;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

[sv/flat_json_object_tokenizer.sv]
// Flat JSON object tokenizer, top level.
// Each request passes the input register, then the result register, before out_valid.
// Throughput: one request per cycle while the output side does not stall; the phase machine updates once per byte.
// Bytes that give no result pass without waiting on the output side.
// Reset (rst_n low, synchronous): phase back to start, no error held, both stages empty.
// Depends on fjot_pkg and fjot_step.
module flat_json_object_tokenizer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [fjot_pkg::ByteW-1:0]  in_text_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fjot_pkg::KindW-1:0]  out_kind,
  output logic [fjot_pkg::ByteW-1:0]  out_data,
  output logic [fjot_pkg::ErrW-1:0]   out_error_code
);

  logic                        in_vld_r;
  logic                        in_op_r;
  logic [fjot_pkg::ByteW-1:0]  in_byte_r;
  logic [fjot_pkg::PhaseW-1:0] phase_r;
  logic [fjot_pkg::PhaseW-1:0] phase_nxt;
  logic [fjot_pkg::ErrW-1:0]   perr_r;
  logic [fjot_pkg::ErrW-1:0]   perr_nxt;
  logic                        out_vld_r;
  logic [fjot_pkg::KindW-1:0]  out_kind_r;
  logic [fjot_pkg::ByteW-1:0]  out_data_r;
  logic [fjot_pkg::ErrW-1:0]   out_err_r;
  fjot_pkg::step_res_t         res;
  logic                        out_free;
  logic                        step_fire;

  fjot_step u_step (
    .phase     (phase_r),
    .perr      (perr_r),
    .opcode    (in_op_r),
    .text_byte (in_byte_r),
    .phase_nxt (phase_nxt),
    .perr_nxt  (perr_nxt),
    .res       (res)
  );

  assign out_free  = !out_vld_r || out_ready;
  assign step_fire = in_vld_r && (!res.vld || out_free);
  assign in_ready  = !in_vld_r || step_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_op_r   <= in_opcode;
      in_byte_r <= in_text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fjot_pkg::PH_START;
      perr_r  <= '0;
    end else if (step_fire) begin
      phase_r <= phase_nxt;
      perr_r  <= perr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= step_fire && res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && res.vld) begin
      out_kind_r <= res.kind;
      out_data_r <= res.data;
      out_err_r  <= res.err;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_kind       = out_kind_r;
  assign out_data       = out_data_r;
  assign out_error_code = out_err_r;

endmodule

[sv/fjot_step.sv]
// Phase machine step for the flat JSON object tokenizer: next phase,
// held error and the result of one request. Pure combinational.
// Depends on fjot_pkg.
module fjot_step (
  input  logic [fjot_pkg::PhaseW-1:0] phase,
  input  logic [fjot_pkg::ErrW-1:0]   perr,
  input  logic                        opcode,
  input  logic [fjot_pkg::ByteW-1:0]  text_byte,
  output logic [fjot_pkg::PhaseW-1:0] phase_nxt,
  output logic [fjot_pkg::ErrW-1:0]   perr_nxt,
  output fjot_pkg::step_res_t         res
);

  logic ws;

  assign ws = fjot_pkg::is_ws(text_byte);

  always_comb begin
    phase_nxt = phase;
    perr_nxt  = perr;
    res       = '0;
    if (opcode == fjot_pkg::OP_END) begin
      phase_nxt = fjot_pkg::PH_START;
      perr_nxt  = '0;
      res.vld   = 1'b1;
      res.kind  = fjot_pkg::K_ERR;
      case (phase)
        fjot_pkg::PH_START: res.err = fjot_pkg::E_NO_BRACE;
        fjot_pkg::PH_AFTER_OPEN, fjot_pkg::PH_AFTER_VAL,
        fjot_pkg::PH_AFTER_COMMA, fjot_pkg::PH_DONE: res.kind = fjot_pkg::K_OK;
        fjot_pkg::PH_KEY, fjot_pkg::PH_KEY_ESC,
        fjot_pkg::PH_VAL, fjot_pkg::PH_VAL_ESC: res.err = fjot_pkg::E_UNTERM;
        fjot_pkg::PH_AFTER_KEY: res.err = fjot_pkg::E_COLON;
        fjot_pkg::PH_BEFORE_VAL, fjot_pkg::PH_KEY_WS: res.err = fjot_pkg::E_QUOTE;
        default: res.err = perr;
      endcase
    end else begin
      case (phase)
        fjot_pkg::PH_START: begin
          if (!ws) begin
            if (text_byte == fjot_pkg::CH_LBRACE) begin
              phase_nxt = fjot_pkg::PH_AFTER_OPEN;
            end else begin
              phase_nxt = fjot_pkg::PH_FAILED;
              perr_nxt  = fjot_pkg::E_NO_BRACE;
            end
          end
        end
        fjot_pkg::PH_AFTER_OPEN: begin
          if (!ws) begin
            if (text_byte == fjot_pkg::CH_RBRACE) begin
              phase_nxt = fjot_pkg::PH_DONE;
            end else if (text_byte == fjot_pkg::CH_QUOTE) begin
              phase_nxt = fjot_pkg::PH_KEY;
            end else begin
              phase_nxt = fjot_pkg::PH_FAILED;
              perr_nxt  = fjot_pkg::E_QUOTE;
            end
          end
        end
        fjot_pkg::PH_AFTER_COMMA, fjot_pkg::PH_KEY_WS: begin
          // whitespace after a comma loses the trailing-comma pass at end
          if (ws) begin
            phase_nxt = fjot_pkg::PH_KEY_WS;
          end else if (text_byte == fjot_pkg::CH_QUOTE) begin
            phase_nxt = fjot_pkg::PH_KEY;
          end else begin
            phase_nxt = fjot_pkg::PH_FAILED;
            perr_nxt  = fjot_pkg::E_QUOTE;
          end
        end
        fjot_pkg::PH_KEY, fjot_pkg::PH_VAL: begin
          if (text_byte == fjot_pkg::CH_QUOTE) begin
            res.vld = 1'b1;
            if (phase == fjot_pkg::PH_KEY) begin
              phase_nxt = fjot_pkg::PH_AFTER_KEY;
              res.kind  = fjot_pkg::K_KEY_END;
            end else begin
              phase_nxt = fjot_pkg::PH_AFTER_VAL;
              res.kind  = fjot_pkg::K_VAL_END;
            end
          end else if (text_byte == fjot_pkg::CH_BSLASH) begin
            phase_nxt = (phase == fjot_pkg::PH_KEY) ? fjot_pkg::PH_KEY_ESC
                                                    : fjot_pkg::PH_VAL_ESC;
          end else begin
            res.vld  = 1'b1;
            res.kind = (phase == fjot_pkg::PH_KEY) ? fjot_pkg::K_KEY_BYTE
                                                   : fjot_pkg::K_VAL_BYTE;
            res.data = text_byte;
          end
        end
        fjot_pkg::PH_KEY_ESC: begin
          phase_nxt = fjot_pkg::PH_KEY;
          res.vld   = 1'b1;
          res.kind  = fjot_pkg::K_KEY_BYTE;
          res.data  = fjot_pkg::unescape(text_byte);
        end
        fjot_pkg::PH_VAL_ESC: begin
          phase_nxt = fjot_pkg::PH_VAL;
          res.vld   = 1'b1;
          res.kind  = fjot_pkg::K_VAL_BYTE;
          res.data  = fjot_pkg::unescape(text_byte);
        end
        fjot_pkg::PH_AFTER_KEY: begin
          if (!ws) begin
            if (text_byte == fjot_pkg::CH_COLON) begin
              phase_nxt = fjot_pkg::PH_BEFORE_VAL;
            end else begin
              phase_nxt = fjot_pkg::PH_FAILED;
              perr_nxt  = fjot_pkg::E_COLON;
            end
          end
        end
        fjot_pkg::PH_BEFORE_VAL: begin
          if (!ws) begin
            if (text_byte == fjot_pkg::CH_QUOTE) begin
              phase_nxt = fjot_pkg::PH_VAL;
            end else begin
              phase_nxt = fjot_pkg::PH_FAILED;
              perr_nxt  = fjot_pkg::E_QUOTE;
            end
          end
        end
        fjot_pkg::PH_AFTER_VAL: begin
          if (!ws) begin
            if (text_byte == fjot_pkg::CH_COMMA) begin
              phase_nxt = fjot_pkg::PH_AFTER_COMMA;
            end else if (text_byte == fjot_pkg::CH_RBRACE) begin
              phase_nxt = fjot_pkg::PH_DONE;
            end else begin
              phase_nxt = fjot_pkg::PH_FAILED;
              perr_nxt  = fjot_pkg::E_COMMA;
            end
          end
        end
        // done, failed and unused codes drop text bytes
        default: begin
          phase_nxt = phase;
        end
      endcase
    end
  end

endmodule
